// File: src/b64c_pkg.sv
// ---------------------------------------------------------------------------
// b64c_pkg: shared types and constants of the base64 codec
// Transaction structs, codec state, result group and alphabet lookups.
// ---------------------------------------------------------------------------
`default_nettype none

package b64c_pkg;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	typedef struct packed {
		logic [7:0] data_in;
		logic       message_last;
	} item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       run_last;
		logic       message_end;
		logic       error_flag;
	} result_t;

	typedef struct packed {
		logic [23:0] group_bits;
		logic [1:0]  group_position;
		logic        padding_seen;
		logic        invalid_seen;
	} codec_state_t;

	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      last_idx;
		logic            emit;
		logic            message_end;
		logic            err_body;
		logic            err_last;
	} group_t;

	localparam logic [7:0] CHAR_PAD = 8'h3D;

	function automatic logic [7:0] enc_char(input logic [5:0] idx);
		logic [7:0] wide;
		wide = {2'b00, idx};
		if (idx < 6'd26) begin
			return wide + 8'h41;
		end else if (idx < 6'd52) begin
			return wide + 8'h47;
		end else if (idx < 6'd62) begin
			return wide - 8'h04;
		end else if (idx == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

	// returns {unknown, index}; unknown characters map to index 63
	function automatic logic [6:0] dec_index(input logic [7:0] c);
		logic [7:0] tmp;
		tmp = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			tmp = c - 8'h41;
			return {1'b0, tmp[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			tmp = c - 8'h47;
			return {1'b0, tmp[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			tmp = c + 8'h04;
			return {1'b0, tmp[5:0]};
		end else if (c == 8'h2B) begin
			return {1'b0, 6'd62};
		end else if (c == 8'h2F) begin
			return {1'b0, 6'd63};
		end else begin
			return {1'b1, 6'd63};
		end
	endfunction

endpackage

`default_nettype wire

// File: src/base64_codec_core.sv
// ---------------------------------------------------------------------------
// base64_codec_core: streaming base64 encoder and decoder
// Standard alphabet with '=' padding, mode selected by a config register.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  item     | item_valid / item_stall | item.data_in, item.message_last
//  result   | result_valid / stall    | result.data_out, run_last, end, error
//  cfg      | cfg_valid / cfg_ready   | cfg_mode
//
// an item is registered, processed in one pass and its group of up to four
// results is parked in a result register that the output port reads one per cycle
// unless stalled; decode takes one character per cycle unless results back up;
// encode is bound by the single result port, four results for three bytes; reset
// clears mode to encode and all message state; cfg_ready is high only idle; a stalled
// result port holds the group; an item forming another waits in the input stage
`default_nettype none

module base64_codec_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  b64c_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output b64c_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_mode
);
	import b64c_pkg::*;

	mode_t        mode_q;
	codec_state_t state_q;
	codec_state_t next_state;
	logic         valid_s1;
	item_t        item_s1;
	logic         valid_s2;
	group_t       grp_s2;
	group_t       step_grp;
	logic [1:0]   idx_q;
	logic         is_last;
	logic         s2_done;
	logic         s2_free;
	logic         s1_advance;
	logic         item_accept;

	b64c_step u_step (
		.mode       (mode_q),
		.state      (state_q),
		.item       (item_s1),
		.next_state (next_state),
		.grp        (step_grp)
	);

	assign is_last     = (idx_q == grp_s2.last_idx);
	assign s2_done     = valid_s2 && !result_stall && is_last;
	assign s2_free     = !valid_s2 || s2_done;
	assign s1_advance  = valid_s1 && (!step_grp.emit || s2_free);
	assign item_stall  = valid_s1 && !s1_advance;
	assign item_accept = item_valid && !item_stall;
	assign cfg_ready   = !valid_s1 && !valid_s2;

	assign result_valid       = valid_s2;
	assign result.data_out    = grp_s2.data[idx_q];
	assign result.run_last    = is_last;
	assign result.message_end = is_last && grp_s2.message_end;
	assign result.error_flag  = is_last ? grp_s2.err_last : grp_s2.err_body;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_ENCODE;
			state_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q  <= mode_t'(cfg_mode);
				state_q <= '0;
			end else if (s1_advance) begin
				state_q <= next_state;
			end
			if (item_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_advance) begin
				valid_s1 <= 1'b0;
			end
			if (s1_advance && step_grp.emit) begin
				valid_s2 <= 1'b1;
				idx_q    <= 2'd0;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end else if (valid_s2 && !result_stall) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			item_s1 <= item;
		end
		if (s1_advance && step_grp.emit) begin
			grp_s2 <= step_grp;
		end
	end

endmodule

`default_nettype wire

// File: src/b64c_step.sv
// ---------------------------------------------------------------------------
// b64c_step: single-item codec step
// Combines one item with the message state and forms its result group.
// ---------------------------------------------------------------------------
`default_nettype none

module b64c_step (
	input  b64c_pkg::mode_t        mode,
	input  b64c_pkg::codec_state_t state,
	input  b64c_pkg::item_t        item,
	output b64c_pkg::codec_state_t next_state,
	output b64c_pkg::group_t       grp
);
	import b64c_pkg::*;

	logic [1:0]  enc_pos;
	logic [1:0]  enc_pos_inc;
	logic [23:0] enc_bits;
	logic        enc_emit;

	logic [6:0]  dec_lookup;
	logic [5:0]  dec_idx;
	logic        dec_pad_hit;
	logic        dec_take;
	logic        dec_full;
	logic        dec_inv;
	logic [23:0] dec_bits;
	logic [1:0]  dec_pos_next;

	always_comb begin
		enc_pos = (state.group_position == 2'd3) ? 2'd0 : state.group_position;
		unique case (enc_pos)
			2'd0:    enc_bits = state.group_bits | {item.data_in, 16'h0000};
			2'd1:    enc_bits = state.group_bits | {8'h00, item.data_in, 8'h00};
			default: enc_bits = state.group_bits | {16'h0000, item.data_in};
		endcase
		enc_pos_inc = enc_pos + 2'd1;
		enc_emit    = (enc_pos_inc == 2'd3) || item.message_last;
	end

	always_comb begin
		dec_lookup   = dec_index(item.data_in);
		dec_idx      = dec_lookup[5:0];
		dec_pad_hit  = !state.padding_seen && (item.data_in == CHAR_PAD) &&
			(state.group_position >= 2'd2);
		dec_take     = !state.padding_seen && !dec_pad_hit;
		dec_inv      = state.invalid_seen || (dec_take && dec_lookup[6]);
		dec_full     = dec_take && (state.group_position == 2'd3);
		dec_pos_next = state.group_position + 2'd1;
		unique case (state.group_position)
			2'd0:    dec_bits = state.group_bits | {dec_idx, 18'h0};
			2'd1:    dec_bits = state.group_bits | {6'h0, dec_idx, 12'h0};
			2'd2:    dec_bits = state.group_bits | {12'h0, dec_idx, 6'h0};
			default: dec_bits = state.group_bits | {18'h0, dec_idx};
		endcase
	end

	always_comb begin
		next_state = state;
		grp        = '0;
		if (mode == MODE_ENCODE) begin
			for (int i = 0; i < 4; i++) begin
				grp.data[i] = (2'(i) <= enc_pos_inc) ? enc_char(enc_bits[23 - 6 * i -: 6])
					: CHAR_PAD;
			end
			grp.last_idx    = 2'd3;
			grp.emit        = enc_emit;
			grp.message_end = item.message_last;
			if (enc_emit) begin
				next_state.group_bits     = '0;
				next_state.group_position = 2'd0;
			end else begin
				next_state.group_bits     = enc_bits;
				next_state.group_position = enc_pos_inc;
			end
		end else begin
			if (dec_pad_hit) begin
				grp.data[0]  = state.group_bits[23:16];
				grp.data[1]  = state.group_bits[15:8];
				grp.last_idx = (state.group_position == 2'd3) ? 2'd1 : 2'd0;
				grp.emit     = 1'b1;
			end else if (dec_full) begin
				grp.data[0]  = dec_bits[23:16];
				grp.data[1]  = dec_bits[15:8];
				grp.data[2]  = dec_bits[7:0];
				grp.last_idx = 2'd2;
				grp.emit     = 1'b1;
			end else if (item.message_last) begin
				grp.emit     = 1'b1;
			end
			grp.message_end = item.message_last;
			grp.err_body    = dec_inv;
			grp.err_last    = dec_inv || (item.message_last && (dec_pos_next != 2'd0));
			if (dec_pad_hit || dec_full) begin
				next_state.group_bits = '0;
			end else if (dec_take) begin
				next_state.group_bits = dec_bits;
			end
			next_state.group_position = dec_pos_next;
			next_state.padding_seen   = state.padding_seen || dec_pad_hit;
			next_state.invalid_seen   = dec_inv;
		end
		if (item.message_last) begin
			next_state = '0;
		end
	end

endmodule

`default_nettype wire

// File: src/b64c_checker.sv
// ---------------------------------------------------------------------------
// b64c_checker: port-level checks of the base64 codec
// Watches handshakes and result grouping; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module b64c_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input b64c_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input b64c_pkg::result_t result,
	input logic              cfg_valid,
	input logic              cfg_ready
);
	import b64c_pkg::*;

	// stalled item transaction holds
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled item changed");

	// stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// a group continues until its run_last result
	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.run_last |=> result_valid)
		else $error("result group broken");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.message_end |-> result.run_last)
		else $error("message end without run last");

	// config taken only while nothing is in flight
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !result_valid && !item_stall)
		else $error("config accepted while busy");

endmodule

bind base64_codec_core b64c_checker u_b64c_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

`default_nettype wire
